/* rtl/gaqs_pkg.sv */
// Shared constants and types for the group absmax quantisation scale core.
`default_nettype none
package gaqs_pkg;
   localparam int COUNT_BITS_DEF = 16;
   localparam int CFG_WIDTH      = 16;
   localparam int HALF_WIDTH     = 16;

   localparam logic [0:0] REG_GROUP_LENGTH = 1'd0;
   localparam logic [0:0] REG_GROUP_TOTAL  = 1'd1;

   localparam logic [CFG_WIDTH-1:0] GROUP_LENGTH_RESET = 16'd32;
   localparam logic [CFG_WIDTH-1:0] GROUP_TOTAL_RESET  = 16'd1;

   localparam logic [14:0] HALF_INF = 15'h7C00;

   // floor(x/127) = (x * RECIP_127) >> 24, exact for x below 2^17
   localparam logic [17:0] RECIP_127  = 18'd132105;
   // 2^20 = 127 * 8256 + 64
   localparam logic [13:0] QUOT_2P20  = 14'd8256;

   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = 2;

   typedef struct packed {
      logic [14:0] peak;
      logic        last;
   } job_entry_type;

   typedef struct packed {
      logic                   full;
      logic                   empty;
      logic [FIFO_PTR_BITS:0] count;
   } fifo_status_type;
endpackage
`default_nettype wire

/* rtl/gaqs_front.sv */
// Front end: config registers, peak tracking and group/job counters.
`default_nettype none
module gaqs_front #(
   parameter int COUNT_BITS = gaqs_pkg::COUNT_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wen,
   input  wire logic [0:0]                     csr_index,
   input  wire logic [gaqs_pkg::CFG_WIDTH-1:0] csr_wdata,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [15:0]                    req_tdata,
   input  wire logic                           fifo_full,
   output logic                                push,
   output gaqs_pkg::job_entry_type             entry
);
   localparam int CW = ((COUNT_BITS > gaqs_pkg::CFG_WIDTH) ?
                        COUNT_BITS : gaqs_pkg::CFG_WIDTH) + 1;
   localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

   logic [gaqs_pkg::CFG_WIDTH-1:0] group_length_ff, group_total_ff;
   logic [14:0]           peak_ff, peak_in;
   logic [COUNT_BITS-1:0] elem_ff, elem_in, grp_ff, grp_in;
   logic [CW-1:0]         len_w, tot_w;
   logic [14:0]           mag;
   logic                  accept, elem_more, grp_more;

   assign req_tready = !fifo_full;
   assign accept     = req_tvalid && req_tready;
   assign mag        = req_tdata[14:0];

   always_comb begin
      len_w = (group_length_ff == '0) ? CW'(1) : CW'(group_length_ff);
      tot_w = (group_total_ff == '0) ? CW'(1) : CW'(group_total_ff);
      elem_more = ((CW'(elem_ff) + CW'(1)) < len_w) && (elem_ff != CMAX);
      grp_more  = ((CW'(grp_ff) + CW'(1)) < tot_w) && (grp_ff != CMAX);
      // NaN words leave the peak alone
      peak_in = (mag <= gaqs_pkg::HALF_INF && mag > peak_ff) ? mag : peak_ff;
      push       = accept && !elem_more;
      entry.peak = peak_in;
      entry.last = !grp_more;
      elem_in = elem_ff;
      grp_in  = grp_ff;
      if (accept) begin
         if (elem_more) begin
            elem_in = elem_ff + COUNT_BITS'(1);
         end else begin
            elem_in = '0;
            grp_in  = grp_more ? grp_ff + COUNT_BITS'(1) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_length_ff <= gaqs_pkg::GROUP_LENGTH_RESET;
         group_total_ff  <= gaqs_pkg::GROUP_TOTAL_RESET;
         peak_ff         <= '0;
         elem_ff         <= '0;
         grp_ff          <= '0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               gaqs_pkg::REG_GROUP_LENGTH: group_length_ff <= csr_wdata;
               gaqs_pkg::REG_GROUP_TOTAL:  group_total_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            peak_ff <= elem_more ? peak_in : 15'd0;
         end
         elem_ff <= elem_in;
         grp_ff  <= grp_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/gaqs_fifo.sv */
// Short queue of closed groups between front and back end.
`default_nettype none
module gaqs_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire gaqs_pkg::job_entry_type push_data,
   input  wire logic                  pop,
   output gaqs_pkg::job_entry_type    pop_data,
   output gaqs_pkg::fifo_status_type  status
);
   localparam int PB = gaqs_pkg::FIFO_PTR_BITS;

   gaqs_pkg::job_entry_type mem_ff [gaqs_pkg::FIFO_DEPTH];
   logic [PB-1:0] wr_ff, rd_ff;
   logic [PB:0]   count_ff;
   logic          do_push, do_pop;

   assign status.count = count_ff;
   assign status.full  = (count_ff == (PB+1)'(gaqs_pkg::FIFO_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push  = push && !status.full;
   assign do_pop   = pop && !status.empty;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + PB'(1);
         if (do_pop)  rd_ff <= rd_ff + PB'(1);
         count_ff <= count_ff + (PB+1)'(do_push) - (PB+1)'(do_pop);
      end
   end
endmodule
`default_nettype wire

/* rtl/gaqs_back.sv */
// Back end: three-stage divide by 127 and binary16 rounding, with output register.
`default_nettype none
module gaqs_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               entry_valid,
   input  wire gaqs_pkg::job_entry_type entry,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [15:0]            rsp_tdata,
   output logic                   rsp_tlast
);
   logic adv;

   // stage 1
   logic        s1_valid_ff, s1_inf_ff, s1_last_ff;
   logic [4:0]  s1_exp_ff;
   logic [10:0] s1_sig_ff;
   logic [34:0] s1_prod_ff;
   // stage 2
   logic        s2_valid_ff, s2_inf_ff, s2_last_ff, s2_sticky_ff;
   logic [4:0]  s2_exp_ff;
   logic [24:0] s2_q_ff;
   // output
   logic        out_valid_ff, out_last_ff;
   logic [15:0] out_bits_ff;

   logic [4:0]  e0;
   logic [10:0] sig0;
   logic [16:0] x0, x1;
   logic [10:0] d1;
   logic [17:0] dd1;
   logic [24:0] q1;

   logic        normal, big, hi, rnd;
   logic [4:0]  shift, expf;
   logic [24:0] remv, half;
   logic [11:0] mant, mant_r;
   logic [15:0] bits;

   assign adv = !out_valid_ff || rsp_tready;
   assign pop = adv && entry_valid;

   always_comb begin
      // subnormal input behaves as exponent one with no hidden bit
      e0   = entry.peak[14:10];
      sig0 = {(e0 != 5'd0), entry.peak[9:0]};
      x0   = {sig0, 6'b0};
      // sig*2^20/127 = sig*8256 + (sig*64)/127
      x1  = {s1_sig_ff, 6'b0};
      d1  = s1_prod_ff[34:24];
      dd1 = {d1, 7'b0} - 18'(d1);
      q1  = 25'(s1_sig_ff * gaqs_pkg::QUOT_2P20) + 25'(d1);

      normal = (s2_exp_ff != 5'd0);
      big    = s2_q_ff[24];
      hi     = normal && ((6'(s2_exp_ff) + 6'(big)) >= 6'd8);
      shift  = hi ? 5'd13 + 5'(big) : 5'd21 - (normal ? s2_exp_ff : 5'd1);
      expf   = s2_exp_ff + 5'(big) - 5'd8;
      mant   = 12'(s2_q_ff >> shift);
      remv   = s2_q_ff & ((25'd1 << shift) - 25'd1);
      half   = 25'd1 << (shift - 5'd1);
      rnd    = (remv > half) || ((remv == half) && (s2_sticky_ff || mant[0]));
      mant_r = mant + 12'(rnd);
      bits   = hi ? (16'({expf, 10'b0}) + 16'(mant_r)) : 16'(mant_r);
      if (s2_inf_ff || bits >= 16'h7C00) begin
         bits = 16'h7C00;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_exp_ff    <= e0;
         s1_sig_ff    <= sig0;
         s1_inf_ff    <= (entry.peak >= gaqs_pkg::HALF_INF);
         s1_last_ff   <= entry.last;
         s1_prod_ff   <= 35'(x0 * gaqs_pkg::RECIP_127);
         s2_exp_ff    <= s1_exp_ff;
         s2_inf_ff    <= s1_inf_ff;
         s2_last_ff   <= s1_last_ff;
         s2_q_ff      <= q1;
         s2_sticky_ff <= (x1 != dd1[16:0]);
         out_bits_ff  <= bits;
         out_last_ff  <= s2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= entry_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_bits_ff;
   assign rsp_tlast  = out_last_ff;
endmodule
`default_nettype wire

/* rtl/group_absmax_quant_scale_core.sv */
// Top level of the group absmax quantisation scale core.
`default_nettype none
// Takes one binary16 word per cycle, tracks the largest non-NaN magnitude of
// each group of group_length words and, when a group closes, returns that
// peak divided by 127, rounded to nearest-even binary16, with tlast set on
// the job's final group (group_total groups; zero in either register counts
// as one). Input words are taken one per cycle; a scale is presented once the
// word closing its group has been written to the queue and has passed a
// three-stage reciprocal multiply and rounding pipeline. A four-entry queue
// between the counters and the divide pipeline lets both sides stall on their
// own; the input stalls only when that queue is full.
module group_absmax_quant_scale_core #(
   parameter int COUNT_BITS = gaqs_pkg::COUNT_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wen,
   input  wire logic [0:0]                     csr_index,
   input  wire logic [gaqs_pkg::CFG_WIDTH-1:0] csr_wdata,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [15:0]                    req_tdata,   // [15:0] element_bits
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [15:0]                         rsp_tdata,   // [15:0] scale_bits
   output logic                                rsp_tlast    // last_of_job
);
   gaqs_pkg::job_entry_type   push_entry, pop_entry;
   gaqs_pkg::fifo_status_type fifo_status;
   logic push, pop;

   gaqs_front #(.COUNT_BITS(COUNT_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .fifo_full  (fifo_status.full),
      .push       (push),
      .entry      (push_entry)
   );

   gaqs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .pop       (pop),
      .pop_data  (pop_entry),
      .status    (fifo_status)
   );

   gaqs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (!fifo_status.empty),
      .entry       (pop_entry),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_no_nan_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[14:10] == 5'h1F) |-> (rsp_tdata[9:0] == 10'd0))
      else $error("scale word is a NaN");
   a_positive_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[15])
      else $error("scale word has sign set");
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_status.count <= (gaqs_pkg::FIFO_PTR_BITS+1)'(gaqs_pkg::FIFO_DEPTH))
      else $error("group queue overfilled");
   a_ready_when_room: assert property (@(posedge clock) disable iff (reset)
      req_tready == !fifo_status.full)
      else $error("input ready out of step with queue");
`endif
endmodule
`default_nettype wire

/* tb/tb_group_absmax_quant_scale_core.sv */
// Self-checking testbench for the group absmax quantisation scale core.
`timescale 1ns / 100ps
`default_nettype none
module tb_group_absmax_quant_scale_core;
   localparam int CNT_MAX = 65535;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic [0:0]  csr_index = gaqs_pkg::REG_GROUP_LENGTH;
   logic [15:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;

   typedef struct packed {
      logic [15:0] scale;
      logic        last;
   } scale_word_type;

   // predictor state
   logic [15:0] len_reg, tot_reg;
   logic [14:0] peak_mag;
   int unsigned elem_pos, grp_pos;

   logic [15:0]    word_queue[$];
   scale_word_type scale_queue[$];
   bit          drv_hold = 1'b1;
   int          burst_left = 0, gap_left = 0;
   int          stall_ctr = 0;
   int          fail_count = 0;
   int          scales_seen = 0;
   int          words_sent = 0;

   group_absmax_quant_scale_core uut (
      .clock(clock), .reset(reset),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always #1 clock = ~clock;

   // round q * 2^p, with sticky, to a binary16 pattern
   function automatic logic [15:0] round_half(longint unsigned q, int p, bit sticky);
      int msb, be, sh;
      longint unsigned mant, rem, hlf;
      longint unsigned bits;
      if (q == 0) return 16'h0;
      msb = 63;
      while (q[msb] == 1'b0) msb--;
      be = msb + p + 15;
      sh = (be >= 1) ? msb - 10 : -24 - p;
      if (sh <= 0) begin
         mant = q << (-sh);
      end else if (sh > 62) begin
         return 16'h0;
      end else begin
         mant = q >> sh;
         rem  = q & ((64'd1 << sh) - 1);
         hlf  = 64'd1 << (sh - 1);
         if (rem > hlf || (rem == hlf && (sticky || mant[0]))) mant++;
      end
      if (be >= 1) begin
         if (be >= 31) return 16'h7C00;
         bits = (longint'(be - 1) << 10) + mant;
      end else begin
         bits = mant;
      end
      if (bits >= 64'h7C00) bits = 64'h7C00;
      return bits[15:0];
   endfunction

   function automatic logic [15:0] peak_over_127(logic [14:0] mag);
      longint unsigned sig, num;
      int p;
      if (mag >= gaqs_pkg::HALF_INF) return 16'h7C00;
      if (mag == 0) return 16'h0;
      if (mag[14:10] == 0) begin
         sig = mag[9:0];
         p = -24;
      end else begin
         sig = {1'b1, mag[9:0]};
         p = int'(mag[14:10]) - 25;
      end
      num = sig << 20;
      return round_half(num / 127, p - 20, (num % 127) != 0);
   endfunction

   task automatic track_word(logic [15:0] w);
      int unsigned len, tot;
      bit last;
      scale_word_type sw;
      len = (len_reg == 0) ? 1 : len_reg;
      tot = (tot_reg == 0) ? 1 : tot_reg;
      if (w[14:0] <= gaqs_pkg::HALF_INF && w[14:0] > peak_mag) peak_mag = w[14:0];
      if (elem_pos + 1 < len && elem_pos < CNT_MAX) begin
         elem_pos++;
         return;
      end
      last = !(grp_pos + 1 < tot && grp_pos < CNT_MAX);
      sw.scale = peak_over_127(peak_mag);
      sw.last = last;
      scale_queue.push_back(sw);
      peak_mag = '0;
      elem_pos = 0;
      grp_pos = last ? 0 : grp_pos + 1;
   endtask

   // driver: bursts and gaps
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            track_word(req_tdata);
            words_sent++;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (gap_left > 0) gap_left--;
            if (!drv_hold && word_queue.size() > 0 && gap_left == 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= word_queue.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor with its own stall pattern
   always @(posedge clock) begin
      scale_word_type exp_w;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            scales_seen++;
            if (scale_queue.size() == 0) begin
               $display("%0t: unexpected scale %h last %b", $time, rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               exp_w = scale_queue.pop_front();
               if (rsp_tdata !== exp_w.scale) begin
                  $display("%0t: scale expected %h actual %h", $time, exp_w.scale, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== exp_w.last) begin
                  $display("%0t: tlast expected %b actual %b", $time, exp_w.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
         stall_ctr++;
         if (stall_ctr < 400) rsp_tready <= 1'b1;
         else if (stall_ctr < 800) rsp_tready <= ((stall_ctr % 7) < 4);
         else if (stall_ctr < 1200) rsp_tready <= ($urandom_range(0, 3) == 0);
         else begin
            rsp_tready <= 1'b1;
            stall_ctr = 0;
         end
      end
   end

   task automatic csr_write(logic [0:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx == gaqs_pkg::REG_GROUP_LENGTH) len_reg = val;
      else tot_reg = val;
   endtask

   task automatic drain_all();
      drv_hold = 1'b0;
      wait (word_queue.size() == 0 && !req_tvalid && scale_queue.size() == 0);
      drv_hold = 1'b1;
      repeat (12) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_half();
      int unsigned k;
      logic [15:0] w;
      k = $urandom_range(0, 9);
      w = $urandom_range(0, 65535);
      case (k)
         0: w[14:10] = 5'h1F;            // inf or NaN
         1: w[14:10] = 5'h00;            // subnormal
         2: w[14:0] = 15'h0;
         3: w[14:10] = 5'h1E;
         default: ;
      endcase
      return w;
   endfunction

   initial begin
      int unsigned gl, gt;
      len_reg = gaqs_pkg::GROUP_LENGTH_RESET;
      tot_reg = gaqs_pkg::GROUP_TOTAL_RESET;
      peak_mag = '0;
      elem_pos = 0;
      grp_pos = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: one group of 32 under the reset settings
      word_queue.push_back(16'h0000);
      word_queue.push_back(16'h8000);
      word_queue.push_back(16'h7E00);          // NaN, ignored
      word_queue.push_back(16'h0001);
      word_queue.push_back(16'h03FF);
      word_queue.push_back(16'hFBFF);
      repeat (26) word_queue.push_back(rand_half());
      drain_all();
      csr_write(gaqs_pkg::REG_GROUP_LENGTH, 16'd1);
      csr_write(gaqs_pkg::REG_GROUP_TOTAL, 16'd0);
      word_queue.push_back(16'h0001); word_queue.push_back(16'h0002);
      word_queue.push_back(16'h03FF); word_queue.push_back(16'h0400);
      word_queue.push_back(16'h7BFF); word_queue.push_back(16'hFC00);
      word_queue.push_back(16'h7C01); word_queue.push_back(16'hFFFF);
      word_queue.push_back(16'h8000); word_queue.push_back(16'h3C00);
      word_queue.push_back(16'h5BF0); word_queue.push_back(16'h0080);
      drain_all();
      csr_write(gaqs_pkg::REG_GROUP_LENGTH, 16'd0);
      csr_write(gaqs_pkg::REG_GROUP_TOTAL, 16'd3);
      repeat (7) word_queue.push_back(rand_half());
      drain_all();

      // random phases with differing group shapes
      for (int ph = 0; ph < 20; ph++) begin
         gl = $urandom_range(1, 12);
         gt = $urandom_range(0, 6);
         if (ph == 5) gl = 16'hFFFF;
         if (ph == 6) gt = 16'hFFFF;
         csr_write(gaqs_pkg::REG_GROUP_LENGTH, gl[15:0]);
         csr_write(gaqs_pkg::REG_GROUP_TOTAL, gt[15:0]);
         for (int i = 0; i < 100; i++) word_queue.push_back(rand_half());
         drain_all();
      end
      $display("Covered %0d words and %0d scales across 23 register settings,",
               words_sent, scales_seen);
      $display("including zero, one and full-range group length and total.");
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire
